@@ sv/qrpt_pkg.sv @@
package qrpt_pkg;

  // Sequencer states of the top level.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SIX_GO,
    ST_SIX_WAIT,
    ST_SQUARE,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_FINISH
  } state_e;

  // Command from the sequencer to the shared remainder unit.
  typedef struct packed {
    logic start;
  } div_ctl_t;

  // Status from the shared remainder unit back to the sequencer.
  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

  // Bias added to the square before the divide by four.
  localparam int unsigned SQ_BIAS   = 3;
  // Divisor used for the 6k+-1 check (odd and not a multiple of three).
  localparam int unsigned SIX_MOD   = 3;
  // Residue that marks a candidate as composite.
  localparam int unsigned HIT_RES   = 1;
  // Largest candidate for which the step loop does not run.
  localparam int unsigned SMALL_MAX = 3;
  // Last difference value examined by the loop.
  localparam int unsigned LAST_DIFF = 3;

endpackage

@@ sv/quadratic_residue_prime_test_unit.sv @@
// Quadratic-residue primality test with 6k+-1 classification.
//
// Input channel (s_axis): one beat carries one candidate in tdata[15:0]; the low
// VALUE_WIDTH bits are used. Output channel (m_axis): one beat per candidate,
// tdata[0] is the prime verdict and tdata[1] the 6k+-1 flag.
//
// The block holds one candidate at a time. A single shift-subtract remainder
// unit does all the work: first the candidate modulo three, then for every
// loop step the residue of the biased square divided by four, modulo the
// candidate. Each loop step squares, starts the remainder unit, waits for the
// remainder and checks it; a candidate n above three runs at most n-3 loop
// steps, fewer when a residue of one ends the loop early. Candidates up to
// three skip the loop and finish after the check modulo three.
//
// The result goes to an output register; the next candidate is accepted while
// it waits there. If the receiver stalls, a finished result waits in the
// sequencer until the output register frees up. Reset empties both and
// returns the sequencer to idle.
module quadratic_residue_prime_test_unit #(
  parameter int unsigned VALUE_WIDTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,   // [15:0] candidate
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o    // [0] is_prime, [1] six_form, [7:2] zero
);
  import qrpt_pkg::*;

  localparam int unsigned W   = VALUE_WIDTH;
  localparam int unsigned DW  = 2 * VALUE_WIDTH - 1;
  localparam int unsigned SQW = 2 * VALUE_WIDTH;

  state_e         state_q, state_d;
  logic [W-1:0]   n_q, n_d;
  logic [W-1:0]   d_q, d_d;
  logic [SQW-1:0] sq_q, sq_d;
  logic           prime_q, prime_d;
  logic           six_q, six_d;
  logic           m_valid_q, m_valid_d;
  logic           m_prime_q, m_prime_d;
  logic           m_six_q, m_six_d;

  div_ctl_t       div_ctl;
  div_sts_t       div_sts;
  logic [DW-1:0]  div_dividend;
  logic [W-1:0]   div_divisor;
  logic [W-1:0]   div_rem;
  logic [SQW:0]   biased;
  logic           step_odd;

  // Step index parity follows from n and the current difference n - j.
  assign step_odd = n_q[0] ^ d_q[0];
  assign biased   = {1'b0, sq_q} + (SQW + 1)'(SQ_BIAS) + (SQW + 1)'(step_odd);

  qrpt_mod_unit #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (div_ctl),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .sts_o      (div_sts),
    .rem_o      (div_rem)
  );

  // Sequencer: next state, datapath updates and output register loading.
  always_comb begin
    state_d      = state_q;
    n_d          = n_q;
    d_d          = d_q;
    sq_d         = sq_q;
    prime_d      = prime_q;
    six_d        = six_q;
    m_valid_d    = m_valid_q;
    m_prime_d    = m_prime_q;
    m_six_d      = m_six_q;
    div_ctl      = '0;
    div_dividend = DW'(n_q);
    div_divisor  = W'(SIX_MOD);

    if (m_valid_q && m_axis_tready_i) begin
      m_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid_i) begin
          n_d     = W'(s_axis_tdata_i);
          state_d = ST_SIX_GO;
        end
      end
      ST_SIX_GO: begin
        div_ctl.start = 1'b1;
        state_d       = ST_SIX_WAIT;
      end
      ST_SIX_WAIT: begin
        if (div_sts.done) begin
          six_d = n_q[0] && (div_rem != '0);
          if (n_q == W'(HIT_RES)) begin
            prime_d = 1'b0;
            state_d = ST_FINISH;
          end else begin
            prime_d = 1'b1;
            if (n_q > W'(SMALL_MAX)) begin
              d_d     = n_q - W'(1);
              state_d = ST_SQUARE;
            end else begin
              state_d = ST_FINISH;
            end
          end
        end
      end
      ST_SQUARE: begin
        sq_d    = SQW'(d_q) * SQW'(d_q);
        state_d = ST_DIV_GO;
      end
      ST_DIV_GO: begin
        div_ctl.start = 1'b1;
        div_dividend  = biased[SQW:2];
        div_divisor   = n_q;
        state_d       = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (div_sts.done) begin
          if (div_rem == W'(HIT_RES)) begin
            prime_d = 1'b0;
            state_d = ST_FINISH;
          end else if (d_q == W'(LAST_DIFF)) begin
            state_d = ST_FINISH;
          end else begin
            d_d     = d_q - W'(1);
            state_d = ST_SQUARE;
          end
        end
      end
      ST_FINISH: begin
        if (!m_valid_q || m_axis_tready_i) begin
          m_valid_d = 1'b1;
          m_prime_d = prime_q;
          m_six_d   = six_q;
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State and output valid registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      m_valid_q <= m_valid_d;
    end
  end

  // Datapath and result registers.
  always_ff @(posedge clk_i) begin
    n_q       <= n_d;
    d_q       <= d_d;
    sq_q      <= sq_d;
    prime_q   <= prime_d;
    six_q     <= six_d;
    m_prime_q <= m_prime_d;
    m_six_q   <= m_six_d;
  end

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {6'b0, m_six_q, m_prime_q};

  // The loop difference stays between three and n - 1 while squaring.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SQUARE) |-> (d_q >= W'(LAST_DIFF) && d_q < n_q))
    else $error("loop difference out of range");

  // The remainder unit only reports completion while the sequencer waits for it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_sts.done |-> (state_q == ST_SIX_WAIT || state_q == ST_DIV_WAIT))
    else $error("remainder result arrived outside a wait state");

  // A result is loaded only into a free or draining output register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FINISH && m_valid_q && !m_axis_tready_i) |=> (state_q == ST_FINISH))
    else $error("result overwrote a pending beat");

endmodule

@@ sv/qrpt_mod_unit.sv @@
module qrpt_mod_unit #(
  parameter int unsigned VALUE_WIDTH = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  qrpt_pkg::div_ctl_t          ctl_i,
  input  logic [2*VALUE_WIDTH-2:0]    dividend_i,
  input  logic [VALUE_WIDTH-1:0]      divisor_i,
  output qrpt_pkg::div_sts_t          sts_o,
  output logic [VALUE_WIDTH-1:0]      rem_o
);
  import qrpt_pkg::*;

  localparam int unsigned W  = VALUE_WIDTH;
  localparam int unsigned DW = 2 * VALUE_WIDTH - 1;
  localparam int unsigned CW = $clog2(DW + 1);

  logic [DW-1:0] dvd_q, dvd_d;
  logic [W-1:0]  dvs_q, dvs_d;
  logic [W-1:0]  rem_q, rem_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic [W:0]    trial;
  logic [W:0]    diff;

  // One restoring step per cycle: shift in the next dividend bit and subtract if it fits.
  assign trial = {rem_q, dvd_q[DW-1]};
  assign diff  = trial - {1'b0, dvs_q};

  always_comb begin
    dvd_d  = dvd_q;
    dvs_d  = dvs_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (ctl_i.start) begin
      dvd_d  = dividend_i;
      dvs_d  = divisor_i;
      rem_d  = '0;
      cnt_d  = CW'(DW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      dvd_d = {dvd_q[DW-2:0], 1'b0};
      if (trial >= {1'b0, dvs_q}) begin
        rem_d = diff[W-1:0];
      end else begin
        rem_d = trial[W-1:0];
      end
      cnt_d = cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Operand and remainder registers.
  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    dvs_q <= dvs_d;
    rem_q <= rem_d;
  end

  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;
  assign rem_o      = rem_q;

  // While busy with a nonzero divisor, the partial remainder stays below the divisor.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && dvs_q != '0) |-> (rem_q < dvs_q))
    else $error("partial remainder not below divisor");

  // A new operation is never started while one is running.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.start |-> !busy_q)
    else $error("remainder unit started while busy");

  // Completion follows the last step and the unit is free at that point.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (!busy_q && $past(busy_q)))
    else $error("done without a finished operation");

endmodule
